### hdl/pcaq_pkg.sv
// Shared types and constants for the priority credit admission queue.
`default_nettype none
package pcaq_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ACQUIRE  = 2'd0,
        CMD_RELEASE  = 2'd1,
        CMD_CANCEL   = 2'd2,
        CMD_SHUTDOWN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_FULL     = 2'd2,
        KIND_GRANT    = 2'd3
    } kind_t;

    localparam logic [0:0] REG_CREDIT_LIMIT = 1'd0;

    // One table entry as held in memory.
    typedef struct packed {
        logic [7:0]  rank;
        logic [31:0] seq;
        logic [31:0] amount;
        logic [15:0] requester;
        logic [15:0] tag;
        logic [31:0] order;
    } entry_t;

    // Memory access request from the controller.
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    // True when entry a is served before entry b.
    function automatic logic ahead(entry_t a, entry_t b);
        if (a.rank != b.rank) return a.rank > b.rank;
        if (a.seq != b.seq) return a.seq < b.seq;
        return a.order < b.order;
    endfunction
endpackage
`default_nettype wire

### hdl/priority_credit_admission_queue.sv
// Top level: credit pool with a pending request table and head-of-line grants.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one request: cmd, amount, rank,
//    arrival_seq, requester, cancel_tag. Output channel (out_valid/out_ready)
//    gives results: kind, grant_requester, grant_amount, free_credit,
//    waiting_count, last. last marks the final result of a request; cancel,
//    shutdown and releases without grants produce no result.
//  - One request is worked at a time. Each head search walks the table
//    memory one entry a cycle in ST_SCAN, then decides in ST_CHECK. A
//    queued acquire or a release searches once, then after each grant
//    (ST_EMIT) searches again; an acquire that grants first sends its
//    accepted status from ST_CHECK. A refused acquire latches its result
//    in the output register directly. Cancel sweeps the table once;
//    shutdown needs no sweep (valid bits are flip-flops).
//  - Results sit in an output register; while the receiver stalls the
//    controller waits with the next result, nothing is dropped.
//  - credit_limit is written over the APB port at address 0. The user must
//    write it only while idle; the block itself does not enforce this.
//  - Reset (rst_n low, asynchronous) empties the table, clears credit,
//    limit, insertion counter and the stopped flag. No clearing pass.
`default_nettype none
module priority_credit_admission_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] amount,
    input  wire logic [7:0]  rank,
    input  wire logic [31:0] arrival_seq,
    input  wire logic [15:0] requester,
    input  wire logic [15:0] cancel_tag,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [15:0]      grant_requester,
    output logic [31:0]      grant_amount,
    output logic [31:0]      free_credit,
    output logic [4:0]       waiting_count,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pcaq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [QUEUE_DEPTH-1:0] used_reg, used_next;
    logic [31:0] limit_reg, limit_next;
    logic [31:0] free_reg, free_next;
    logic [31:0] order_reg, order_next;
    logic        stopped_reg, stopped_next;
    logic [IDX_W:0] scan_reg, scan_next;     // address issued this cycle
    logic        head_vld_reg, head_vld_next;
    logic [IDX_W-1:0] head_idx_reg, head_idx_next;
    entry_t      head_reg, head_next;
    logic        pend_reg, pend_next;          // a result waits to be sent at end
    logic        ov_reg, ov_next;
    logic [1:0]  okind_reg, okind_next;
    logic [15:0] oreq_reg, oreq_next;
    logic [31:0] oamt_reg, oamt_next;
    logic [31:0] ofree_reg, ofree_next;
    logic [4:0]  ocnt_reg, ocnt_next;
    logic        olast_reg, olast_next;

    mem_req_t mreq;
    entry_t   rd_data;

    pcaq_table_mem u_mem (.clk(clk), .req(mreq), .rd_data(rd_data));

    logic [IDX_W-1:0] free_slot;
    logic             any_free;
    logic [CNT_W-1:0] cnt_now;
    logic [IDX_W-1:0] prev_idx;
    logic [32:0]      rel_sum;
    logic [31:0]      used_credit;
    logic             cfg_wr;

    always_comb
    begin
        free_slot = '0;
        any_free = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = IDX_W'(i);
                any_free = 1'b1;
            end
        end
    end

    assign cnt_now  = CNT_W'($countones(used_reg));
    assign prev_idx = scan_reg[IDX_W-1:0] - IDX_W'(1);
    assign rel_sum  = {1'b0, free_reg} + {1'b0, amount};
    assign used_credit = limit_reg - free_reg;
    assign cfg_wr   = psel && penable && pwrite && (paddr == REG_CREDIT_LIMIT);

    assign in_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_CREDIT_LIMIT) ? limit_reg : 32'd0;

    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;
        limit_next = limit_reg;
        free_next = free_reg;
        order_next = order_reg;
        stopped_next = stopped_reg;
        scan_next = scan_reg;
        head_vld_next = head_vld_reg;
        head_idx_next = head_idx_reg;
        head_next = head_reg;
        pend_next = pend_reg;
        ov_next = ov_reg && !out_ready;
        okind_next = okind_reg;
        oreq_next = oreq_reg;
        oamt_next = oamt_reg;
        ofree_next = ofree_reg;
        ocnt_next = ocnt_reg;
        olast_next = olast_reg;
        mreq = '0;
        mreq.rd_addr = scan_reg[IDX_W-1:0];

        if (cfg_wr)
        begin
            limit_next = pwdata;
            free_next = (pwdata > used_credit) ? pwdata - used_credit : 32'd0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_ACQUIRE:
                        begin
                            ov_next = 1'b1;
                            okind_next = KIND_ACCEPTED;
                            oreq_next = '0;
                            oamt_next = '0;
                            ofree_next = free_reg;
                            olast_next = 1'b1;
                            ocnt_next = 5'(cnt_now);
                            if (amount == 32'd0 || amount > limit_reg || stopped_reg)
                            begin
                                okind_next = KIND_REJECTED;
                            end
                            else if (!any_free)
                            begin
                                okind_next = KIND_FULL;
                            end
                            else
                            begin
                                // hold the accepted status until grants are known
                                ov_next = 1'b0;
                                pend_next = 1'b1;
                                ocnt_next = 5'(cnt_now + CNT_W'(1));
                                mreq.wr_en = 1'b1;
                                mreq.wr_addr = free_slot;
                                mreq.wr_data = '{rank: rank, seq: arrival_seq,
                                    amount: amount, requester: requester,
                                    tag: cancel_tag, order: order_reg};
                                used_next[free_slot] = 1'b1;
                                order_next = order_reg + 32'd1;
                                scan_next = '0;
                                head_vld_next = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            free_next = (rel_sum > {1'b0, limit_reg}) ? limit_reg
                                                                    : rel_sum[31:0];
                            pend_next = 1'b0;
                            if (!stopped_reg)
                            begin
                                scan_next = '0;
                                head_vld_next = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            scan_next = '0;
                            head_vld_next = 1'b0;
                            state_next = ST_SCAN;
                            pend_next = 1'b0;
                        end
                        CMD_SHUTDOWN:
                        begin
                            stopped_next = 1'b1;
                            used_next = '0;
                        end
                        default: ;
                    endcase
                    // cancel reuses the scan with a marker: head_idx unused
                    if (cmd_t'(cmd) == CMD_CANCEL)
                    begin
                        head_next.requester = requester;
                        head_next.tag = cancel_tag;
                        stopped_next = stopped_reg;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                // cancel sweep: compare each entry as it is read
                if (scan_reg != '0 && used_reg[prev_idx] &&
                    rd_data.requester == head_reg.requester &&
                    rd_data.tag == head_reg.tag)
                begin
                    used_next[prev_idx] = 1'b0;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == (IDX_W+1)'(QUEUE_DEPTH))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg != '0 && used_reg[prev_idx] &&
                    (!head_vld_reg || ahead(rd_data, head_reg)))
                begin
                    head_vld_next = 1'b1;
                    head_idx_next = prev_idx;
                    head_next = rd_data;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == (IDX_W+1)'(QUEUE_DEPTH))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!ov_reg || out_ready)
                begin
                    if (head_vld_reg && head_reg.amount <= free_reg)
                    begin
                        if (pend_reg)
                        begin
                            ov_next = 1'b1;
                            olast_next = 1'b0;
                            pend_next = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        if (pend_reg)
                        begin
                            ov_next = 1'b1;
                            olast_next = 1'b1;
                            pend_next = 1'b0;
                        end
                        else if (ov_reg && okind_reg == KIND_GRANT)
                        begin
                            // last grant is already latched and leaving now
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    free_next = free_reg - head_reg.amount;
                    used_next[head_idx_reg] = 1'b0;
                    ov_next = 1'b1;
                    okind_next = KIND_GRANT;
                    oreq_next = head_reg.requester;
                    oamt_next = head_reg.amount;
                    ofree_next = free_reg - head_reg.amount;
                    ocnt_next = 5'(cnt_now - CNT_W'(1));
                    olast_next = 1'b0;
                    scan_next = '0;
                    head_vld_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // last on a grant is decided by the following search; hold the grant
    // in a staging slot until then.
    logic        stg_reg, stg_next;
    logic        fin_now;

    assign fin_now = (state_reg == ST_CHECK) && !pend_reg &&
                     !(head_vld_reg && head_reg.amount <= free_reg);

    always_comb
    begin
        stg_next = stg_reg;
        if (state_reg == ST_EMIT && (!ov_reg || out_ready)) stg_next = 1'b1;
        if (state_reg == ST_CHECK && stg_reg) stg_next = 1'b0;
    end

    logic show;
    assign show = ov_reg && !(stg_reg && okind_reg == KIND_GRANT &&
                              state_reg != ST_IDLE && state_reg != ST_CHECK);
    assign out_valid = show && !(state_reg == ST_CHECK && stg_reg);
    assign kind = okind_reg;
    assign grant_requester = oreq_reg;
    assign grant_amount = oamt_reg;
    assign free_credit = ofree_reg;
    assign waiting_count = ocnt_reg;
    assign last = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            limit_reg <= '0;
            free_reg <= '0;
            order_reg <= '0;
            stopped_reg <= 1'b0;
            scan_reg <= '0;
            head_vld_reg <= 1'b0;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
            stg_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
            limit_reg <= limit_next;
            free_reg <= free_next;
            order_reg <= order_next;
            stopped_reg <= stopped_next;
            scan_reg <= scan_next;
            head_vld_reg <= head_vld_next;
            pend_reg <= pend_next;
            stg_reg <= stg_next;
            if (state_reg == ST_CHECK && stg_reg)
            begin
                ov_reg <= 1'b1;
            end
            else
            begin
                ov_reg <= ov_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_idx_reg <= head_idx_next;
        head_reg <= head_next;
        okind_reg <= okind_next;
        oreq_reg <= oreq_next;
        oamt_reg <= oamt_next;
        ofree_reg <= ofree_next;
        ocnt_reg <= ocnt_next;
        if (state_reg == ST_CHECK && stg_reg)
        begin
            olast_reg <= fin_now;
        end
        else
        begin
            olast_reg <= olast_next;
        end
    end
endmodule
`default_nettype wire

### hdl/pcaq_table_mem.sv
// Entry table memory: one write port, one registered read port.
`default_nettype none
module pcaq_table_mem (
    input  wire logic              clk,
    input  wire pcaq_pkg::mem_req_t req,
    output pcaq_pkg::entry_t       rd_data
);
    import pcaq_pkg::*;

    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end
endmodule
`default_nettype wire

### hdl/pcaq_checker.sv
// Port-level checker for the priority credit admission queue, bound to the top.
`default_nettype none
module pcaq_port_props (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  kind,
    input wire logic [15:0] grant_requester,
    input wire logic [31:0] grant_amount,
    input wire logic [4:0]  waiting_count,
    input wire logic        last
);
    import pcaq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind))
        else $error("result dropped while stalled");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_REJECTED || kind == KIND_FULL) |-> last)
        else $error("refusal not final");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_GRANT |-> grant_amount == 32'd0 &&
                                            grant_requester == 16'd0)
        else $error("status carries grant data");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> waiting_count <= 5'(QUEUE_DEPTH))
        else $error("waiting count exceeds depth");

    // a new request is taken only once every result has left
    a_in_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("request taken while a result waits");
endmodule

bind priority_credit_admission_queue pcaq_port_props u_pcaq_port_props (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .grant_requester(grant_requester), .grant_amount(grant_amount),
    .waiting_count(waiting_count), .last(last)
);
`default_nettype wire

### sim/pcaq_checker.sv
// Checker for the admission queue: watches requests and results, predicts, compares.
module pcaq_checker
    import pcaq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] amount,
    input  logic [7:0]  rank,
    input  logic [31:0] arrival_seq,
    input  logic [15:0] requester,
    input  logic [15:0] cancel_tag,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] grant_requester,
    input  logic [31:0] grant_amount,
    input  logic [31:0] free_credit,
    input  logic [4:0]  waiting_count,
    input  logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);
    typedef struct {
        kind_t       kind;
        logic [15:0] who;
        logic [31:0] amt;
        logic [31:0] free_after;
        logic [4:0]  waiting;
        logic        lst;
    } outcome_t;

    outcome_t    outcomes[$];
    logic        busy_slot[QUEUE_DEPTH];
    entry_t      slot[QUEUE_DEPTH];
    logic [31:0] insert_count;
    logic [31:0] pool_free;
    logic [31:0] pool_limit;
    logic        halted;

    assign pending = outcomes.size();

    function automatic logic [4:0] occupancy();
        logic [4:0] n;
        n = 0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            n += 5'(busy_slot[i]);
        return n;
    endfunction

    function automatic logic served_first(int a, int b);
        if (slot[a].rank != slot[b].rank) return slot[a].rank > slot[b].rank;
        if (slot[a].seq != slot[b].seq) return slot[a].seq < slot[b].seq;
        return slot[a].order < slot[b].order;
    endfunction

    function automatic void note(kind_t k, logic [15:0] who, logic [31:0] amt);
        outcome_t o;
        o.kind = k;
        o.who = who;
        o.amt = amt;
        o.free_after = pool_free;
        o.waiting = occupancy();
        o.lst = 1'b0;
        outcomes = {outcomes, o};
    endfunction

    // Head-of-line grants until the head no longer fits.
    function automatic void grant_heads();
        int head;
        forever begin
            head = -1;
            for (int i = 0; i < QUEUE_DEPTH; i++)
                if (busy_slot[i] && (head < 0 || served_first(i, head)))
                    head = i;
            if (head < 0 || slot[head].amount > pool_free) break;
            pool_free -= slot[head].amount;
            busy_slot[head] = 1'b0;
            note(KIND_GRANT, slot[head].requester, slot[head].amount);
        end
    endfunction

    function automatic void predict_request();
        int          prior_count;
        int          free_idx;
        logic [32:0] sum;
        prior_count = outcomes.size();
        case (cmd_t'(cmd))
            CMD_ACQUIRE: begin
                free_idx = -1;
                for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
                    if (!busy_slot[i]) free_idx = i;
                if (amount == 0 || amount > pool_limit || halted)
                    note(KIND_REJECTED, '0, '0);
                else if (free_idx < 0)
                    note(KIND_FULL, '0, '0);
                else begin
                    busy_slot[free_idx] = 1'b1;
                    slot[free_idx] = '{rank: rank, seq: arrival_seq, amount: amount,
                                       requester: requester, tag: cancel_tag,
                                       order: insert_count};
                    insert_count++;
                    note(KIND_ACCEPTED, '0, '0);
                    grant_heads();
                end
            end
            CMD_RELEASE: begin
                sum = {1'b0, pool_free} + {1'b0, amount};
                pool_free = (sum > {1'b0, pool_limit}) ? pool_limit : sum[31:0];
                if (!halted) grant_heads();
            end
            CMD_CANCEL: begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (busy_slot[i] && slot[i].requester == requester
                        && slot[i].tag == cancel_tag)
                        busy_slot[i] = 1'b0;
            end
            default: begin
                halted = 1'b1;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    busy_slot[i] = 1'b0;
            end
        endcase
        if (outcomes.size() > prior_count) outcomes[outcomes.size() - 1].lst = 1'b1;
    endfunction

    function automatic void check_result();
        outcome_t o;
        if (outcomes.size() == 0) begin
            $error("result with nothing expected: kind %0d", kind);
            fail_count++;
            return;
        end
        o = outcomes.pop_front();
        if (kind != o.kind) begin
            $error("kind: expected %0d, got %0d", o.kind, kind); fail_count++;
        end
        if (grant_requester != o.who) begin
            $error("grant_requester: expected %0h, got %0h", o.who, grant_requester);
            fail_count++;
        end
        if (grant_amount != o.amt) begin
            $error("grant_amount: expected %0d, got %0d", o.amt, grant_amount);
            fail_count++;
        end
        if (free_credit != o.free_after) begin
            $error("free_credit: expected %0d, got %0d", o.free_after, free_credit);
            fail_count++;
        end
        if (waiting_count != o.waiting) begin
            $error("waiting_count: expected %0d, got %0d", o.waiting, waiting_count);
            fail_count++;
        end
        if (last != o.lst) begin
            $error("last: expected %0d, got %0d", o.lst, last); fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                busy_slot[i] = 1'b0;
            insert_count = '0;
            pool_free = '0;
            pool_limit = '0;
            halted = 1'b0;
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_CREDIT_LIMIT) begin
                // used credit is preserved; free floors at zero
                pool_free = (pwdata > pool_limit - pool_free)
                            ? pwdata - (pool_limit - pool_free) : '0;
                pool_limit = pwdata;
            end
            if (out_valid && out_ready) check_result();
            if (in_valid && in_ready) predict_request();
        end
    end
endmodule

### sim/tb_priority_credit_admission_queue.sv
// Testbench top: drives requests and credit limit writes, reports the verdict.
module tb_priority_credit_admission_queue;
    import pcaq_pkg::*;

    localparam int SETTLE_CYCLES = 400;   // outlasts the longest silent request
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 500;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [31:0] amount;
    logic [7:0]  rank;
    logic [31:0] arrival_seq;
    logic [15:0] requester;
    logic [15:0] cancel_tag;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [15:0] grant_requester;
    logic [31:0] grant_amount;
    logic [31:0] free_credit;
    logic [4:0]  waiting_count;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          cycle_count;
    logic        no_gaps;       // back-to-back stretch on both sides
    logic        hold_results;  // asks the receiver for one long stall
    logic [31:0] cur_limit;

    priority_credit_admission_queue dut (.*);

    pcaq_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_priority_credit_admission_queue: errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 13);
    endfunction

    // Result receiver: random stalls per result, plus one long hold-off
    // while the sender keeps offering, so the block backs up into in_ready.
    initial
    begin
        int   gap;
        logic held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results && !held)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send(cmd_t c, logic [31:0] amt, logic [7:0] rk, logic [31:0] seq,
                        logic [15:0] who, logic [15:0] tag);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd = c;
        amount = amt;
        rank = rk;
        arrival_seq = seq;
        requester = who;
        cancel_tag = tag;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid, drain all expected results, then let silent work finish.
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(logic [31:0] value);
        settle();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_CREDIT_LIMIT;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        cur_limit = value;
    endtask

    // Random request: mostly small amounts around the limit and a small
    // owner pool so cancels hit; now and then full-range fields.
    task automatic random_request();
        cmd_t        c;
        logic [31:0] amt;
        logic [15:0] who;
        logic [15:0] tag;
        int          roll;
        roll = $urandom_range(0, 99);
        c = (roll < 55) ? CMD_ACQUIRE : (roll < 88) ? CMD_RELEASE : CMD_CANCEL;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            amt = 0;
        else if (roll < 3)
            amt = $urandom();
        else if (cur_limit == 0)
            amt = $urandom_range(1, 8);
        else
            amt = $urandom_range(1, (cur_limit > 64'd2000) ? 2000 : cur_limit + 1);
        if ($urandom_range(0, 9) == 0)
        begin
            who = 16'($urandom());
            tag = 16'($urandom());
        end
        else
        begin
            who = 16'($urandom_range(0, 3));
            tag = 16'($urandom_range(0, 1));
        end
        send(c, amt, 8'($urandom()), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
             : $urandom(), who, tag);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            random_request();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        no_gaps = 1'b0;
        hold_results = 1'b0;
        cur_limit = 0;
        in_valid = 1'b0;
        cmd = CMD_ACQUIRE;
        amount = '0;
        rank = '0;
        arrival_seq = '0;
        requester = '0;
        cancel_tag = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = REG_CREDIT_LIMIT;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: rejects, rank and seq order, head-of-line blocking,
        // saturating release, insertion-order ties, cancel matching.
        write_limit(100);
        send(CMD_ACQUIRE, 0, 0, 0, 16'h0001, 0);
        send(CMD_ACQUIRE, 101, 0, 0, 16'h0001, 0);
        send(CMD_ACQUIRE, 60, 5, 10, 16'h0002, 0);
        send(CMD_ACQUIRE, 50, 8'hFF, 32'hFFFF_FFFF, 16'h0003, 0);
        send(CMD_ACQUIRE, 30, 8'hFF, 0, 16'h0004, 0);
        send(CMD_ACQUIRE, 5, 0, 0, 16'h0005, 0);
        send(CMD_RELEASE, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send(CMD_ACQUIRE, 70, 7, 9, 16'h0006, 0);
        send(CMD_ACQUIRE, 70, 7, 9, 16'h0007, 0);
        send(CMD_RELEASE, 25, 0, 0, 0, 0);
        send(CMD_RELEASE, 100, 0, 0, 0, 0);
        send(CMD_ACQUIRE, 100, 1, 1, 16'hFFFF, 16'hFFFF);
        send(CMD_ACQUIRE, 90, 1, 2, 16'hFFFF, 16'hFFFF);
        send(CMD_CANCEL, 0, 0, 0, 16'hFFFF, 16'h7FFF);
        send(CMD_RELEASE, 0, 0, 0, 0, 0);
        send(CMD_CANCEL, 0, 0, 0, 16'hFFFF, 16'hFFFF);
        send(CMD_RELEASE, 100, 0, 0, 0, 0);

        // Fill the table behind a blocked head, then overflow it.
        write_limit(20);
        send(CMD_ACQUIRE, 20, 8'hFF, 0, 16'h0010, 0);
        for (int i = 0; i < 17; i++)
            send(CMD_ACQUIRE, 20, 8'($urandom()), $urandom(), 16'h0011, 16'h0001);
        // Lower the limit under the pending head: it blocks until cancelled.
        write_limit(10);
        send(CMD_RELEASE, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send(CMD_CANCEL, 0, 0, 0, 16'h0011, 16'h0001);

        write_limit(1000);
        hold_results = 1'b1;
        random_phase(60);
        write_limit(32'hFFFF_FFFF);
        random_phase(50);
        write_limit(0);
        random_phase(10);
        write_limit(50);
        random_phase(60);
        write_limit(300);
        random_phase(40);

        // Shutdown last: only reset would clear it.
        send(CMD_SHUTDOWN, 0, 0, 0, 0, 0);
        send(CMD_ACQUIRE, 5, 1, 1, 16'h0001, 0);
        send(CMD_RELEASE, 100, 0, 0, 0, 0);
        send(CMD_CANCEL, 0, 0, 0, 16'h0001, 0);

        settle();
        if (fail_count == 0)
            $display("tb_priority_credit_admission_queue: clean");
        else
            $display("tb_priority_credit_admission_queue: errors");
        $finish;
    end
endmodule
